@@ src/elapsed_time_recorder_core_defines.svh @@
// Assertion macros used by the checker of the elapsed time recorder.
// Depends on nothing; included by the checker file.
`ifndef ELAPSED_TIME_RECORDER_CORE_DEFINES_SVH
`define ELAPSED_TIME_RECORDER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/etr_pkg.sv @@
// Types and constants of the elapsed time recorder.
// Used by the divider, the core and the checker; depends on nothing.
`default_nettype none

package etr_pkg;

   localparam int RECORD_DEPTH = 64;
   localparam int PTR_W        = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
   localparam int CNT_W        = $clog2(RECORD_DEPTH + 1);
   localparam int CALC_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;

   localparam int OPC_W = 3;
   localparam int NS_W  = 63;
   localparam int US_W  = 54;
   localparam int MS_W  = 44;
   localparam int OFS_W = 8;

   localparam logic [OPC_W-1:0] OP_SET_BEGIN     = 3'd0;
   localparam logic [OPC_W-1:0] OP_STORE         = 3'd1;
   localparam logic [OPC_W-1:0] OP_ADD_STORE     = 3'd2;
   localparam logic [OPC_W-1:0] OP_CLEAR_ELAPSED = 3'd3;
   localparam logic [OPC_W-1:0] OP_RECORD        = 3'd4;
   localparam logic [OPC_W-1:0] OP_CLEAR_RECORDS = 3'd5;
   localparam logic [OPC_W-1:0] OP_READ_RECORD   = 3'd6;

   localparam logic [NS_W-1:0] NS_MAX = '1;

   localparam int NS_PER_US = 1000;
   localparam int NS_PER_MS = 1000000;

   // Constant divider by reciprocal multiplication. For every 63-bit x,
   // x / 1000 equals (x * US_RECIP) >> 73 and x / 1000000 equals (x * MS_RECIP) >> 83.
   // The 63 by 64 bit products are built from four 32 by 32 bit partial products.
   localparam int DIV_HALF_W = 32;
   localparam int DIV_PROD_W = 2 * DIV_HALF_W;
   localparam int DIV_ACC_W  = DIV_PROD_W + 2;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);
   localparam int US_SHIFT   = 73 - DIV_PROD_W;
   localparam int MS_SHIFT   = 83 - DIV_PROD_W;

   localparam logic [DIV_PROD_W-1:0] US_RECIP = 64'd9444732965739290428;
   localparam logic [DIV_PROD_W-1:0] MS_RECIP = 64'd9671406556917033398;

   typedef struct packed {
      logic [OPC_W-1:0] opcode;
      logic [NS_W-1:0]  now_time;
      logic [NS_W-1:0]  begin_time;
      logic             move_beginning;
      logic [OFS_W-1:0] record_offset;
   } req_type;

   typedef struct packed {
      logic [NS_W-1:0] elapsed_ns;
      logic [US_W-1:0] elapsed_us;
      logic [MS_W-1:0] elapsed_ms;
      logic [NS_W-1:0] begin_now;
      logic            record_valid;
      logic [US_W-1:0] record_value;
   } rsp_type;

   typedef struct packed {
      logic            start;
      logic [NS_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [US_W-1:0] quot_us;
      logic [MS_W-1:0] quot_ms;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ src/etr_div.sv @@
// Shared constant divider: nanoseconds to microseconds and milliseconds.
// Two reciprocal multipliers run in lockstep over four partial products; depends on etr_pkg.
`default_nettype none

module etr_div import etr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [NS_W-1:0]       num_ff, num_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_ACC_W-1:0]  acc_us_ff, acc_us_in;
   logic [DIV_ACC_W-1:0]  acc_ms_ff, acc_ms_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIV_HALF_W-1:0] num_part;
   logic [DIV_HALF_W-1:0] us_part;
   logic [DIV_HALF_W-1:0] ms_part;
   logic [DIV_PROD_W-1:0] prod_us;
   logic [DIV_PROD_W-1:0] prod_ms;
   logic [DIV_ACC_W-1:0]  base_us;
   logic [DIV_ACC_W-1:0]  base_ms;

   // Step bit 1 picks the dividend half and step bit 0 the reciprocal half.
   assign num_part = step_ff[1] ? DIV_HALF_W'(num_ff[NS_W-1:DIV_HALF_W])
                                : num_ff[DIV_HALF_W-1:0];
   assign us_part  = step_ff[0] ? US_RECIP[DIV_PROD_W-1:DIV_HALF_W]
                                : US_RECIP[DIV_HALF_W-1:0];
   assign ms_part  = step_ff[0] ? MS_RECIP[DIV_PROD_W-1:DIV_HALF_W]
                                : MS_RECIP[DIV_HALF_W-1:0];

   assign prod_us = DIV_PROD_W'(us_part) * DIV_PROD_W'(num_part);
   assign prod_ms = DIV_PROD_W'(ms_part) * DIV_PROD_W'(num_part);

   // Before a product with the upper reciprocal half is added, the running sum drops its
   // low 32 bits, so that after the last step it holds the full product above bit 63.
   assign base_us = step_ff[0] ? (acc_us_ff >> DIV_HALF_W) : acc_us_ff;
   assign base_ms = step_ff[0] ? (acc_ms_ff >> DIV_HALF_W) : acc_ms_ff;

   always_comb begin
      num_in    = num_ff;
      step_in   = step_ff;
      acc_us_in = acc_us_ff;
      acc_ms_in = acc_ms_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (div_req.start) begin
         num_in    = div_req.dividend;
         step_in   = '0;
         acc_us_in = '0;
         acc_ms_in = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_us_in = base_us + DIV_ACC_W'(prod_us);
         acc_ms_in = base_ms + DIV_ACC_W'(prod_ms);
         step_in   = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      acc_us_ff <= acc_us_in;
      acc_ms_ff <= acc_ms_in;
   end

   assign div_rsp.done    = done_ff;
   assign div_rsp.quot_us = acc_us_ff[US_SHIFT +: US_W];
   assign div_rsp.quot_ms = acc_ms_ff[MS_SHIFT +: MS_W];

endmodule

`default_nettype wire

@@ src/elapsed_time_recorder_core.sv @@
// Elapsed time recorder: a stopwatch with a ring of recorded microsecond values.
// Request channel req_*, result channel rsp_*, both valid/ready; one result per request.
// Each request carries the current time in ns; the result shows the state after it.
// The recorder handles one request at a time: req_ready is high only while it is free.
// Steps from the accepted request to the raising of rsp_valid (receiver ready):
//   store and add_store: execute, the shared constant divider, reply;
//     the divider forms ns / 1000 and ns / 1000000 by reciprocal multiplication,
//     one 32 x 32 partial product a cycle for each.
//   all other commands: execute or ring read, reply.
// req_ready returns as the reply is loaded, together with rsp_valid; a new request
// is accepted only after the reply of the previous one has been loaded.
// A record writes the ring memory; a read_record reads it in the execute step,
// and the read data is registered before the reply.
// Results sit in an output register; the next request is accepted while a result waits,
// and its result is held back until the receiver takes the previous one.
// Reset clears the beginning, the saved elapsed time, the ring pointer and the record
// count; the ring contents are not cleared, and only written entries are reported.
// Depends on etr_pkg and etr_div.
`default_nettype none

module elapsed_time_recorder_core import etr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_REPLY  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [NS_W-1:0]  span_ff, span_in;
   logic [NS_W-1:0]  beginning_ff, beginning_in;
   logic [NS_W-1:0]  saved_ff, saved_in;
   logic [US_W-1:0]  us_ff, us_in;
   logic [MS_W-1:0]  ms_ff, ms_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rec_valid_ff, rec_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [US_W-1:0]  ring_mem [RECORD_DEPTH];
   logic [US_W-1:0]  rd_ff;
   logic             mem_we;
   logic             mem_re;
   logic [PTR_W-1:0] mem_addr;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic [NS_W:0]    diff;
   logic [NS_W:0]    sum;
   logic [PTR_W-1:0] ptr_next;
   logic [CALC_W-1:0] ptr_ext;
   logic [CALC_W-1:0] off_ext;
   logic [CALC_W-1:0] idx_ext;
   logic             rd_ok;

   etr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Time before the beginning counts as no time at all.
   assign diff = {1'b0, req_data.now_time} - {1'b0, beginning_ff};
   assign sum  = {1'b0, saved_ff} + {1'b0, span_ff};

   assign ptr_next = (ptr_ff == PTR_W'(RECORD_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   assign ptr_ext = CALC_W'(ptr_ff);
   assign off_ext = CALC_W'(req_ff.record_offset);
   assign idx_ext = (ptr_ext >= off_ext) ? ptr_ext - off_ext
                                         : ptr_ext + CALC_W'(RECORD_DEPTH) - off_ext;
   assign rd_ok   = (off_ext < CALC_W'(RECORD_DEPTH)) && (off_ext < CALC_W'(cnt_ff));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      span_in      = span_ff;
      beginning_in = beginning_ff;
      saved_in     = saved_ff;
      us_in        = us_ff;
      ms_in        = ms_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      rec_valid_in = rec_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = ptr_next;
      div_req.start = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               span_in  = diff[NS_W] ? '0 : diff[NS_W-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_REPLY;
            rec_valid_in = 1'b0;
            case (req_ff.opcode)
               OP_SET_BEGIN: begin
                  beginning_in = (req_ff.begin_time < req_ff.now_time) ? req_ff.begin_time
                                                                        : req_ff.now_time;
               end
               OP_STORE, OP_ADD_STORE: begin
                  if (req_ff.opcode == OP_STORE) begin
                     saved_in = span_ff;
                  end else begin
                     saved_in = sum[NS_W] ? NS_MAX : sum[NS_W-1:0];
                  end
                  if (req_ff.move_beginning) begin
                     beginning_in = req_ff.now_time;
                  end
                  div_req.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
               OP_CLEAR_ELAPSED: begin
                  saved_in = '0;
                  us_in    = '0;
                  ms_in    = '0;
               end
               OP_RECORD: begin
                  ptr_in = ptr_next;
                  if (cnt_ff != CNT_W'(RECORD_DEPTH)) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  mem_we = 1'b1;
               end
               OP_CLEAR_RECORDS: begin
                  ptr_in = '0;
                  cnt_in = '0;
               end
               OP_READ_RECORD: begin
                  rec_valid_in = rd_ok;
                  mem_re       = 1'b1;
                  mem_addr     = idx_ext[PTR_W-1:0];
               end
               default: begin
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               us_in    = div_rsp.quot_us;
               ms_in    = div_rsp.quot_ms;
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.elapsed_ns   = saved_ff;
               rsp_in.elapsed_us   = us_ff;
               rsp_in.elapsed_ms   = ms_ff;
               rsp_in.begin_now    = beginning_ff;
               rsp_in.record_valid = rec_valid_ff;
               rsp_in.record_value = rec_valid_ff ? rd_ff : '0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      div_req.dividend = saved_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beginning_ff <= '0;
         saved_ff     <= '0;
         us_ff        <= '0;
         ms_ff        <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beginning_ff <= beginning_in;
         saved_ff     <= saved_in;
         us_ff        <= us_in;
         ms_ff        <= ms_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      span_ff      <= span_in;
      rec_valid_ff <= rec_valid_in;
      rsp_ff       <= rsp_in;
   end

   // Record ring: one write or one read per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= us_ff;
      end
      if (mem_re) begin
         rd_ff <= ring_mem[mem_addr];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ src/etr_checker.sv @@
// Port-level checks of the elapsed time recorder, bound to elapsed_time_recorder_core.
// Depends on etr_pkg and elapsed_time_recorder_core_defines.svh.
`default_nettype none

`include "elapsed_time_recorder_core_defines.svh"

module etr_checker import etr_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `ETR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
   `ETR_ASSERT_IMPL(a_value_gated, clock, reset, rsp_valid && !rsp_data.record_valid, rsp_data.record_value == '0, "record value without valid record")
   `ETR_ASSERT_IMPL(a_units_order, clock, reset, rsp_valid, (rsp_data.elapsed_ms <= rsp_data.elapsed_us) && (rsp_data.elapsed_us <= rsp_data.elapsed_ns), "elapsed units out of order")
   `ETR_ASSERT_NEXT(a_one_at_once, clock, reset, req_valid && req_ready, !req_ready, "second request taken while busy")
   `ETR_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready, "block not idle after reset")

endmodule

bind elapsed_time_recorder_core etr_checker u_etr_checker (.*);

`default_nettype wire
